// File: hw/rtl/btb_pkg.sv
// Shared constants and types for the branch target buffer predictor.
package btb_pkg;

    localparam int ENTRIES     = 1024;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int CNT_W       = $clog2(ENTRIES + 1);
    localparam int ADDR_W      = 24;
    localparam int CFG_W       = 11;
    localparam int HIT_W       = 32;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_FIELD_W = 1 + 1 + ADDR_W + 2 + 1 + HIT_W + HIT_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(1024);

    typedef enum logic [1:0] {
        OUTC_NONE = 2'd0,
        OUTC_HIT  = 2'd1,
        OUTC_MISS = 2'd2
    } outcome_t;

    // One table slot as stored in memory, source address in the low bits.
    typedef struct packed {
        logic [1:0]        counter;
        logic [ADDR_W-1:0] target;
        logic [ADDR_W-1:0] source;
    } btb_entry_t;

    localparam int ENTRY_W = $bits(btb_entry_t);

endpackage

// File: hw/rtl/btb_ram.sv
// Simple dual-port RAM, one write and one registered read port.
module btb_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 50
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hw/rtl/branch_target_buffer_predictor.sv
// Top level of the branch target buffer predictor with two-bit counters.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+---------------------------------------
//  s_*     | in  | s_tvalid/s_tready | s_tdata: address
//  m_*     | out | m_tvalid/m_tready | m_tdata: found, taken, target, outcome,
//          |     |                   |   inserted, hit count, miss count
//  cfg_*   | in  | cfg_wr_en         | cfg_wr_data: active_entries
//
// Search: slots are read in order from slot 0, and the search ends at the first match
// or after the last searched slot (min of fill and active size); with an empty table
// the search is skipped and the block goes straight to resolve. The single
// read port of the table memory sets this: one slot is compared per cycle.
// Reset: asynchronous, active low; the table has no clearing pass.
// Stalls: a held result in the output register does not block accepting and
// searching the next address; only the final update waits for the output slot.
module branch_target_buffer_predictor (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [btb_pkg::IN_TDATA_W-1:0]   s_tdata,   // [23:0] address
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] entry_found, [1] predicted_taken, [25:2] predicted_target,
    // [27:26] outcome, [28] inserted, [60:29] hit_count, [92:61] miss_count
    output logic [btb_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [btb_pkg::CFG_W-1:0]        cfg_wr_data
);

    import btb_pkg::*;

    localparam int CMP_W = (CFG_W > CNT_W) ? CFG_W : CNT_W;
    localparam logic [CMP_W-1:0] ENTRIES_C = CMP_W'(ENTRIES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESOLVE
    } state_t;

    state_t                 state_reg, state_next;
    logic [CFG_W-1:0]       active_reg, active_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic [ADDR_W-1:0]      prev_reg, prev_next;       // last accepted address
    logic [ADDR_W-1:0]      key_reg, key_next;         // address being judged
    logic [ADDR_W-1:0]      cur_reg, cur_next;         // address that followed it
    logic                   taken_reg, taken_next;
    logic [CNT_W-1:0]       limit_reg, limit_next;
    logic [CNT_W-1:0]       scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       pos_reg, pos_next;
    btb_entry_t             hit_entry_reg, hit_entry_next;
    logic [HIT_W-1:0]       hits_reg, hits_next;
    logic [HIT_W-1:0]       misses_reg, misses_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    btb_entry_t             ram_wdata;
    logic                   ram_re;
    logic [IDX_W-1:0]       ram_raddr;
    btb_entry_t             ram_rdata;

    logic [CMP_W-1:0]       active_wide;
    logic [CNT_W-1:0]       size;
    logic [CNT_W-1:0]       limit_now;
    logic [ADDR_W-1:0]      s_addr;
    logic [ADDR_W:0]        prev_plus4;
    logic                   accept;
    logic                   out_free;
    logic                   predict;
    logic [1:0]             cnt_new;
    outcome_t               outc;
    logic                   ins;

    btb_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Effective table size: active size clamped to the table depth.
    assign active_wide = CMP_W'(active_reg);
    assign size        = (active_wide > ENTRIES_C) ? CNT_W'(ENTRIES_C) : CNT_W'(active_wide);
    assign limit_now   = (fill_reg < size) ? fill_reg : size;

    assign s_addr     = s_tdata[ADDR_W-1:0];
    assign prev_plus4 = {1'b0, prev_reg} + (ADDR_W + 1)'(4);   // no wrap
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Prediction and counter move for the matched slot.
    assign predict = (hit_entry_reg.counter <= 2'd1);

    always_comb
    begin
        if (taken_reg)
        begin
            cnt_new = (hit_entry_reg.counter != 2'd0) ? hit_entry_reg.counter - 2'd1
                                                      : hit_entry_reg.counter;
        end
        else
        begin
            cnt_new = (hit_entry_reg.counter != 2'd3) ? hit_entry_reg.counter + 2'd1
                                                      : hit_entry_reg.counter;
        end
    end

    always_comb
    begin
        ins = 1'b0;
        if (found_reg)
        begin
            outc = (predict == taken_reg) ? OUTC_HIT : OUTC_MISS;
        end
        else if (taken_reg)
        begin
            outc = OUTC_MISS;
            ins  = (fill_reg < size);
        end
        else
        begin
            outc = OUTC_NONE;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        fill_next      = fill_reg;
        prev_next      = prev_reg;
        key_next       = key_reg;
        cur_next       = cur_reg;
        taken_next     = taken_reg;
        limit_next     = limit_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_vld_next   = 1'b0;
        found_next     = found_reg;
        pos_next       = pos_reg;
        hit_entry_next = hit_entry_reg;
        hits_next      = hits_reg;
        misses_next    = misses_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = hit_entry_reg;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        if (cfg_wr_en)
        begin
            active_next = cfg_wr_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next   = prev_reg;
                    cur_next   = s_addr;
                    prev_next  = s_addr;
                    taken_next = (prev_reg != '0) && ({1'b0, s_addr} != prev_plus4);
                    limit_next = limit_now;
                    found_next = 1'b0;
                    if (limit_now != '0)
                    begin
                        // first slot read goes out with the accept
                        ram_re        = 1'b1;
                        ram_raddr     = '0;
                        cmp_idx_next  = '0;
                        cmp_vld_next  = 1'b1;
                        scan_idx_next = CNT_W'(1);
                        state_next    = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_RESOLVE;
                    end
                end
            end

            ST_SCAN:
            begin
                if (cmp_vld_reg && (ram_rdata.source == key_reg))
                begin
                    found_next     = 1'b1;
                    pos_next       = cmp_idx_reg;
                    hit_entry_next = ram_rdata;
                    state_next     = ST_RESOLVE;
                end
                else if (cmp_vld_reg && ((CNT_W'(cmp_idx_reg) + CNT_W'(1)) == limit_reg))
                begin
                    state_next = ST_RESOLVE;
                end
                else if (scan_idx_reg < limit_reg)
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = scan_idx_reg[IDX_W-1:0];
                    cmp_idx_next  = scan_idx_reg[IDX_W-1:0];
                    cmp_vld_next  = 1'b1;
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
            end

            ST_RESOLVE:
            begin
                if (out_free)
                begin
                    // commit table, totals and result in the same cycle
                    if (found_reg)
                    begin
                        ram_we            = 1'b1;
                        ram_waddr         = pos_reg;
                        ram_wdata         = hit_entry_reg;
                        ram_wdata.counter = cnt_new;
                    end
                    else if (ins)
                    begin
                        ram_we            = 1'b1;
                        ram_waddr         = fill_reg[IDX_W-1:0];
                        ram_wdata.source  = key_reg;
                        ram_wdata.target  = cur_reg;
                        ram_wdata.counter = 2'd0;
                        fill_next         = fill_reg + CNT_W'(1);
                    end

                    if ((outc == OUTC_HIT) && (hits_reg != '1))
                    begin
                        hits_next = hits_reg + HIT_W'(1);
                    end
                    if ((outc == OUTC_MISS) && (misses_reg != '1))
                    begin
                        misses_next = misses_reg + HIT_W'(1);
                    end

                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_TDATA_W'({
                        ((outc == OUTC_MISS) && (misses_reg != '1)) ? misses_reg + HIT_W'(1)
                                                                     : misses_reg,
                        ((outc == OUTC_HIT) && (hits_reg != '1)) ? hits_reg + HIT_W'(1)
                                                                  : hits_reg,
                        ins,
                        outc,
                        found_reg ? hit_entry_reg.target : {ADDR_W{1'b0}},
                        found_reg && predict,
                        found_reg
                    });
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= ACTIVE_RESET;
            fill_reg      <= '0;
            prev_reg      <= '0;
            cmp_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            fill_reg      <= fill_next;
            prev_reg      <= prev_next;
            cmp_vld_reg   <= cmp_vld_next;
            found_reg     <= found_next;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        cur_reg       <= cur_next;
        taken_reg     <= taken_next;
        limit_reg     <= limit_next;
        scan_idx_reg  <= scan_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        pos_reg       <= pos_next;
        hit_entry_reg <= hit_entry_next;
        m_tdata_reg   <= m_tdata_next;
    end

`ifndef ASSERT_OFF
    // table is written only while committing a transaction
    a_write_in_resolve: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_RESOLVE && out_free))
        else $error("table write outside commit");

    // fill count never runs past the table depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(fill_reg) <= ENTRIES_C)
        else $error("fill count beyond table depth");

    // an accepted address always leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("accept did not start a search");

    // compared slot lies inside the searched range
    a_cmp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && cmp_vld_reg) |-> (CNT_W'(cmp_idx_reg) < limit_reg))
        else $error("compare outside searched range");
`endif

endmodule

// File: tb/branch_target_buffer_predictor_tb.sv
// Self-checking testbench for the branch target buffer predictor.
module branch_target_buffer_predictor_tb;

    import btb_pkg::*;

    // Cycles with no transaction on either channel before the run is abandoned.
    // The limit sits above the slowest lookup and the long receiver hold-off.
    localparam int STALL_LIMIT     = 20000;
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int DRAIN_CYCLES    = 50;
    localparam int LOOPS           = 6;

    // One result as the block reports it, in the order of the m_tdata fields.
    typedef struct packed {
        logic              found;
        logic              taken;
        logic [ADDR_W-1:0] target;
        outcome_t          outcome;
        logic              inserted;
        logic [HIT_W-1:0]  hits;
        logic [HIT_W-1:0]  misses;
    } score_t;

    // Directed row: address, whether the expected score is typed in, and that score.
    typedef struct packed {
        logic [ADDR_W-1:0] pc;
        logic              pinned;
        score_t            want;
    } probe_t;

    localparam score_t UNPINNED = '0;

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    s_tvalid    = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata     = '0;    // [23:0] address
    logic                    m_tvalid;
    logic                    m_tready    = 1'b0;
    // [0] found, [1] taken, [25:2] target, [27:26] outcome, [28] inserted,
    // [60:29] hit count, [92:61] miss count
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]        cfg_wr_data = '0;

    // Predictor state: the table, fill level, last address, totals, active size.
    logic [ADDR_W-1:0] slot_src [ENTRIES];
    logic [ADDR_W-1:0] slot_tgt [ENTRIES];
    logic [1:0]        slot_ctr [ENTRIES];
    int unsigned       slots_used  = 0;
    logic [ADDR_W-1:0] last_pc     = '0;
    logic [HIT_W-1:0]  hit_total   = '0;
    logic [HIT_W-1:0]  miss_total  = '0;
    logic [CFG_W-1:0]  active_size = ACTIVE_RESET;

    score_t pending_scores [$];
    score_t oldest;
    int     mismatches    = 0;
    bit     gaps_on       = 1'b1;
    bit     hold_off_req  = 1'b0;

    // Address stream generator: a pool of small loops, each closed by a backward
    // branch at base + 4 * len, plus occasional jumps and noise addresses.
    logic [ADDR_W-1:0] loop_base [LOOPS];
    int                loop_len  [LOOPS];
    int                cur_loop  = 0;
    int                loop_pos  = -1;

    // Directed part. Rows with the pinned bit carry a hand-derived score: the
    // first steps after reset and the wrap at the top of the address range.
    probe_t probes [25] = '{
        '{24'h000000, 1'b1, '{1'b0, 1'b0, 24'h0, OUTC_NONE, 1'b0, 32'd0, 32'd0}},
        '{24'h000100, 1'b1, '{1'b0, 1'b0, 24'h0, OUTC_NONE, 1'b0, 32'd0, 32'd0}},
        '{24'h000104, 1'b1, '{1'b0, 1'b0, 24'h0, OUTC_NONE, 1'b0, 32'd0, 32'd0}},
        '{24'h000100, 1'b1, '{1'b0, 1'b0, 24'h0, OUTC_MISS, 1'b1, 32'd0, 32'd1}},
        '{24'h000104, 1'b1, '{1'b0, 1'b0, 24'h0, OUTC_NONE, 1'b0, 32'd0, 32'd1}},
        '{24'h000100, 1'b0, UNPINNED},
        '{24'h000104, 1'b0, UNPINNED},
        '{24'h000108, 1'b0, UNPINNED},
        '{24'h000104, 1'b0, UNPINNED},
        '{24'h000108, 1'b0, UNPINNED},
        '{24'h00010C, 1'b0, UNPINNED},
        '{24'h000100, 1'b0, UNPINNED},
        '{24'h000104, 1'b0, UNPINNED},
        '{24'h000108, 1'b0, UNPINNED},
        '{24'h000104, 1'b0, UNPINNED},
        '{24'h000108, 1'b0, UNPINNED},   // counter already at 3, stays there
        '{24'hFFFFFC, 1'b0, UNPINNED},
        // previous + 4 does not wrap, so FFFFFC -> 000000 is a taken branch
        '{24'h000000, 1'b1, '{1'b0, 1'b0, 24'h0, OUTC_MISS, 1'b1, 32'd5, 32'd7}},
        // zero previous address never counts as taken
        '{24'hFFFFFF, 1'b1, '{1'b0, 1'b0, 24'h0, OUTC_NONE, 1'b0, 32'd5, 32'd7}},
        '{24'hFFFFFC, 1'b0, UNPINNED},
        '{24'h000000, 1'b0, UNPINNED},
        '{24'hAAAAAA, 1'b0, UNPINNED},
        '{24'h555555, 1'b0, UNPINNED},
        '{24'hFFFFFF, 1'b0, UNPINNED},
        '{24'hFFFFFC, 1'b0, UNPINNED}
    };

    branch_target_buffer_predictor i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Scores the step that ended at the previous address and updates the table.
    function automatic score_t score_step(input logic [ADDR_W-1:0] pc);
        score_t      s;
        int unsigned span;
        int unsigned searched;
        int unsigned slot;
        int unsigned i;
        logic        taken;
        logic        found;
        logic [1:0]  c;
        span     = (active_size > ENTRIES) ? ENTRIES : active_size;
        searched = (slots_used < span) ? slots_used : span;
        // previous + 4 formed one bit wider: no wrap at the top of the range
        taken    = (last_pc != '0) && ({1'b0, pc} != ({1'b0, last_pc} + 25'd4));
        found    = 1'b0;
        slot     = 0;
        s        = '0;
        for (i = 0; i < searched; i++)
        begin
            if (!found && slot_src[i] == last_pc)
            begin
                found = 1'b1;
                slot  = i;
            end
        end
        if (found)
        begin
            c        = slot_ctr[slot];
            s.found  = 1'b1;
            s.taken  = (c <= 2'd1);
            s.target = slot_tgt[slot];
            if (s.taken == taken)
            begin
                if (hit_total != '1)
                    hit_total = hit_total + HIT_W'(1);
                s.outcome = OUTC_HIT;
            end
            else
            begin
                if (miss_total != '1)
                    miss_total = miss_total + HIT_W'(1);
                s.outcome = OUTC_MISS;
            end
            if (taken)
            begin
                if (c != 2'd0)
                    c = c - 2'd1;
            end
            else if (c != 2'd3)
                c = c + 2'd1;
            slot_ctr[slot] = c;
        end
        else if (taken)
        begin
            if (miss_total != '1)
                miss_total = miss_total + HIT_W'(1);
            s.outcome = OUTC_MISS;
            if (slots_used < span)
            begin
                slot_src[slots_used] = last_pc;
                slot_tgt[slots_used] = pc;
                slot_ctr[slots_used] = 2'd0;
                slots_used++;
                s.inserted = 1'b1;
            end
        end
        last_pc  = pc;
        s.hits   = hit_total;
        s.misses = miss_total;
        return s;
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // Next executed address: mostly loop traffic, some jumps, a little noise.
    function automatic logic [ADDR_W-1:0] next_pc();
        int                r;
        logic [ADDR_W-1:0] pc;
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            pc       = ADDR_W'($urandom());
            loop_pos = -1;
        end
        else if (r < 6)
        begin
            pc       = (r == 5) ? '1 : '0;
            loop_pos = -1;
        end
        else if (r < 14 || loop_pos < 0)
        begin
            cur_loop = $urandom_range(0, LOOPS - 1);
            loop_pos = 0;
            pc       = loop_base[cur_loop];
        end
        else if (loop_pos == loop_len[cur_loop])
        begin
            // branch site: usually back to the top, sometimes fall through
            if ($urandom_range(0, 3) != 0)
            begin
                loop_pos = 0;
                pc       = loop_base[cur_loop];
            end
            else
            begin
                pc       = loop_base[cur_loop] + ADDR_W'(4 * (loop_len[cur_loop] + 1));
                loop_pos = -1;
            end
        end
        else
        begin
            loop_pos++;
            pc = loop_base[cur_loop] + ADDR_W'(4 * loop_pos);
        end
        return pc;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endfunction

    // Offers one address and returns at the edge where it is accepted.
    task automatic send_address(input logic [ADDR_W-1:0] pc);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pc;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Drains the block, writes the active size, then streams random addresses.
    task automatic run_phase(input logic [CFG_W-1:0] size, input int count,
                             input bit idle, input bit squeeze);
        int                n;
        logic [ADDR_W-1:0] pc;
        s_tvalid <= 1'b0;
        while (pending_scores.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= size;
        active_size  = size;
        @(posedge clk);
        cfg_wr_en <= 1'b0;

        gaps_on = idle;
        // fresh loops per phase so the table keeps growing
        for (n = 0; n < LOOPS; n++)
        begin
            loop_base[n] = ADDR_W'($urandom_range(0, 22'h3FFFC0)) << 2;
            loop_len[n]  = $urandom_range(1, 5);
        end
        loop_pos = -1;
        if (squeeze)
            hold_off_req = 1'b1;

        for (n = 0; n < count; n++)
        begin
            pc = next_pc();
            send_address(pc);
            pending_scores.push_back(score_step(pc));
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin : receiver
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    // Result checker: every transaction on the master side against the oldest score.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_scores.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none actual %h", $time, m_tdata);
            end
            else
            begin
                oldest = pending_scores.pop_front();
                check_field("entry_found", 32'(oldest.found), 32'(m_tdata[0]));
                check_field("predicted_taken", 32'(oldest.taken), 32'(m_tdata[1]));
                check_field("predicted_target", 32'(oldest.target), 32'(m_tdata[25:2]));
                check_field("outcome", 32'(oldest.outcome), 32'(m_tdata[27:26]));
                check_field("inserted", 32'(oldest.inserted), 32'(m_tdata[28]));
                check_field("hit_count", oldest.hits, m_tdata[60:29]);
                check_field("miss_count", oldest.misses, m_tdata[92:61]);
            end
        end
    end

    // Watchdog: any transaction on either channel restarts the count.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin : stimulus
        int k;
        score_t s;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows run at the reset size of 1024
        for (k = 0; k < 25; k++)
        begin
            send_address(probes[k].pc);
            s = score_step(probes[k].pc);
            pending_scores.push_back(probes[k].pinned ? probes[k].want : s);
        end

        run_phase(11'd0, 40, 1'b1, 1'b0);       // nothing found, nothing inserted
        run_phase(11'd1, 40, 1'b1, 1'b0);       // lowered after filling: slot 0 only
        run_phase(11'd12, 80, 1'b0, 1'b0);      // fills up, no idling on either side
        run_phase(11'd2047, 150, 1'b1, 1'b1);   // clamped to the table size, long stall
        run_phase(11'd40, 110, 1'b1, 1'b0);
        run_phase(11'd1024, 130, 1'b1, 1'b0);
        s_tvalid <= 1'b0;

        while (pending_scores.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
